// ===== rtl/core/gcb_pkg.sv =====
// package for the 9x14 glyph cell blitter: item kinds, cell geometry,
// keep masks and sequencer states; no dependencies
`timescale 1ns / 1ps

package gcb_pkg;

  typedef enum logic [1:0] {
    KIND_DRAW = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  localparam int CELL_SCANS       = 14;
  localparam int FIRST_GLYPH_SCAN = 3;
  localparam int GLYPH_ROWS       = 8;
  localparam logic [3:0] LAST_SCAN = 4'(CELL_SCANS - 1);

  // bits of the old frame byte that survive, by bit offset of the cell
  localparam logic [7:0] KEEP_FIRST [8] = '{
    8'h00, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE, 8'hFF
  };
  localparam logic [7:0] KEEP_NEXT [8] = '{
    8'h3F, 8'h1F, 8'h0F, 8'h07, 8'h03, 8'h01, 8'h00, 8'h00
  };

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_RD_FIRST = 8'b0000_0100,
    ST_WR_FIRST = 8'b0000_1000,
    ST_WR_NEXT  = 8'b0001_0000,
    ST_RD_ISSUE = 8'b0010_0000,
    ST_RD_CAPT  = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_e;

endpackage

// ===== rtl/core/glyph_cell_blitter_9x14_core.sv =====
// 9x14 text cell blitter: frame buffer, glyph store and draw sequencer
// depends on gcb_pkg
`timescale 1ns / 1ps

// Usage
//   Input words arrive on the s_axis channel, the kind in s_axis_tuser:
//   draw a character cell, load one glyph row, or read one frame byte.
//   Every input word gives exactly one output word on m_axis, holding the
//   frame byte for a read and zero for every other kind.
//   A draw runs one shared read-modify-write path over the 14 scanlines of
//   the cell, a first-byte and a next-byte write per scanline; a read
//   passes through the issue and capture states, while a glyph load, an
//   off-screen draw or an ignored word goes straight to the result state.
//   s_axis_tready returns in the same cycle that the result appears.
//   s_axis_tready is high only while the sequencer is idle.
//   The result sits in an output register; the next word is accepted while
//   it waits, and a finished word holds the sequencer until m_axis is free.
//   After reset the frame buffer is cleared one byte per cycle, all
//   TEXT_LINES*14*ROW_BYTES bytes (44800 with the defaults); no word is
//   accepted meanwhile. The glyph store is not cleared and must be loaded
//   before the characters that use it are drawn.
module glyph_cell_blitter_9x14_core
  import gcb_pkg::*;
#(
  parameter int TEXT_LINES = 25,
  parameter int TEXT_COLS  = 80,
  parameter int ROW_BYTES  = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], text_line[12:8], text_col[19:13], glyph_row[22:20],
  // glyph_bits[30:23], scan_row[39:31], row_byte[46:40], zero[47]
  input  logic [47:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0]
  output logic [7:0]  m_axis_tdata
);

  localparam int SCAN_LINES  = TEXT_LINES * CELL_SCANS;
  localparam int FRAME_BYTES = SCAN_LINES * ROW_BYTES;
  localparam int SCAN_BYTES  = CELL_SCANS * ROW_BYTES;
  localparam int FA_W        = $clog2(FRAME_BYTES);

  // input fields
  logic [7:0] in_char_code;
  logic [4:0] in_text_line;
  logic [6:0] in_text_col;
  logic [2:0] in_glyph_row;
  logic [7:0] in_glyph_bits;
  logic [8:0] in_scan_row;
  logic [6:0] in_row_byte;

  assign in_char_code  = s_axis_tdata[7:0];
  assign in_text_line  = s_axis_tdata[12:8];
  assign in_text_col   = s_axis_tdata[19:13];
  assign in_glyph_row  = s_axis_tdata[22:20];
  assign in_glyph_bits = s_axis_tdata[30:23];
  assign in_scan_row   = s_axis_tdata[39:31];
  assign in_row_byte   = s_axis_tdata[46:40];

  state_e          state_q, state_d;
  logic [FA_W-1:0] clr_q, clr_d;
  logic [FA_W-1:0] base_q, base_d;
  logic [3:0]      scan_q, scan_d;
  logic [7:0]      code_q, code_d;
  logic [2:0]      k_q, k_d;
  logic [7:0]      first_q, first_d;
  logic            first_ok_q, first_ok_d;
  logic            next_ok_q, next_ok_d;
  logic            rd_ok_q, rd_ok_d;
  logic [7:0]      result_q, result_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_data_q, out_data_d;

  // memories
  logic [7:0]      frame_mem [FRAME_BYTES];
  logic [7:0]      glyph_mem [CELL_SCANS * 0 + 2048];
  logic            fr_we, fr_re;
  logic [FA_W-1:0] fr_waddr, fr_raddr;
  logic [7:0]      fr_wdata, fr_rdata_q;
  logic            gl_we, gl_re;
  logic [10:0]     gl_waddr, gl_raddr;
  logic [7:0]      gl_wdata, gl_rdata_q;

  logic            accept;
  logic [7:0]      next_byte;
  logic [7:0]      glyph_bits;
  logic [3:0]      scan_load;
  logic [3:0]      glyph_sel;
  logic [FA_W-1:0] base_up;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign next_byte = first_q + 8'd1;
  assign base_up   = base_q + FA_W'(ROW_BYTES);

  // blanked scanlines draw an all-zero row
  assign glyph_bits = (scan_q >= 4'(FIRST_GLYPH_SCAN) &&
                       scan_q < 4'(FIRST_GLYPH_SCAN + GLYPH_ROWS)) ? gl_rdata_q : 8'h00;

  // glyph row fetched in the cycle before the scanline that uses it
  assign scan_load = (state_q == ST_RD_FIRST) ? 4'd0 : scan_q + 4'd1;
  assign glyph_sel = scan_load - 4'(FIRST_GLYPH_SCAN);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    base_d      = base_q;
    scan_d      = scan_q;
    code_d      = code_q;
    k_d         = k_q;
    first_d     = first_q;
    first_ok_d  = first_ok_q;
    next_ok_d   = next_ok_q;
    rd_ok_d     = rd_ok_q;
    result_d    = result_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    fr_we    = 1'b0;
    fr_waddr = base_q + FA_W'(first_q);
    fr_wdata = 8'h00;
    fr_re    = 1'b0;
    fr_raddr = base_q + FA_W'(first_q);
    gl_we    = 1'b0;
    gl_waddr = {in_char_code, in_glyph_row};
    gl_wdata = in_glyph_bits;
    gl_re    = 1'b0;
    gl_raddr = {code_q, glyph_sel[2:0]};

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        fr_we    = 1'b1;
        fr_waddr = clr_q;
        fr_wdata = 8'h00;
        clr_d    = clr_q + FA_W'(1);
        if (clr_q == FA_W'(FRAME_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          result_d = 8'h00;
          state_d  = ST_DONE;
          case (s_axis_tuser)
            KIND_DRAW: begin
              if (in_text_line < TEXT_LINES && in_text_col < TEXT_COLS) begin
                // col*9/8 is col plus col/8
                first_d    = {1'b0, in_text_col} + {4'd0, in_text_col[6:3]};
                first_ok_d = {1'b0, first_d} < 9'(ROW_BYTES);
                next_ok_d  = ({1'b0, first_d} + 9'd1) < 9'(ROW_BYTES);
                k_d        = in_text_col[2:0];
                code_d     = in_char_code;
                base_d     = FA_W'(FA_W'(in_text_line) * FA_W'(SCAN_BYTES));
                scan_d     = 4'd0;
                state_d    = ST_RD_FIRST;
              end
            end
            KIND_LOAD: begin
              gl_we = 1'b1;
            end
            KIND_READ: begin
              rd_ok_d = (in_scan_row < SCAN_LINES) && (in_row_byte < ROW_BYTES);
              base_d  = FA_W'(FA_W'(in_scan_row) * FA_W'(ROW_BYTES)) + FA_W'(in_row_byte);
              state_d = ST_RD_ISSUE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_FIRST: begin
        fr_re   = 1'b1;
        gl_re   = 1'b1;
        state_d = ST_WR_FIRST;
      end
      ST_WR_FIRST: begin
        fr_we    = first_ok_q;
        fr_wdata = (fr_rdata_q & KEEP_FIRST[k_q]) | 8'(glyph_bits >> ({1'b0, k_q} + 4'd1));
        fr_re    = 1'b1;
        fr_raddr = base_q + FA_W'(next_byte);
        state_d  = ST_WR_NEXT;
      end
      ST_WR_NEXT: begin
        fr_we    = next_ok_q;
        fr_waddr = base_q + FA_W'(next_byte);
        fr_wdata = (fr_rdata_q & KEEP_NEXT[k_q]) | 8'(glyph_bits << (3'd7 - k_q));
        if (scan_q == LAST_SCAN) begin
          state_d = ST_DONE;
        end else begin
          // fetch the first byte and glyph row of the following scanline
          fr_re    = 1'b1;
          fr_raddr = base_up + FA_W'(first_q);
          gl_re    = 1'b1;
          base_d   = base_up;
          scan_d   = scan_q + 4'd1;
          state_d  = ST_WR_FIRST;
        end
      end
      ST_RD_ISSUE: begin
        fr_re    = 1'b1;
        fr_raddr = base_q;
        state_d  = ST_RD_CAPT;
      end
      ST_RD_CAPT: begin
        result_d = rd_ok_q ? fr_rdata_q : 8'h00;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = result_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    code_q     <= code_d;
    k_q        <= k_d;
    first_q    <= first_d;
    first_ok_q <= first_ok_d;
    next_ok_q  <= next_ok_d;
    rd_ok_q    <= rd_ok_d;
    result_q   <= result_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      frame_mem[fr_waddr] <= fr_wdata;
    end
    if (fr_re) begin
      fr_rdata_q <= frame_mem[fr_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gl_we) begin
      glyph_mem[gl_waddr] <= gl_wdata;
    end
    if (gl_re) begin
      gl_rdata_q <= glyph_mem[gl_raddr];
    end
  end

  // no word taken while the frame buffer is still being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input accepted during frame clear");

  // frame writes only come from the clear pass or the draw path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_we |-> (state_q == ST_CLEAR || state_q == ST_WR_FIRST || state_q == ST_WR_NEXT))
    else $error("frame write outside clear or draw");

  // scanline counter stays inside the cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_FIRST || state_q == ST_WR_NEXT) |-> (scan_q <= LAST_SCAN))
    else $error("scanline counter out of cell");

  // a new result only appears when the sequencer finishes a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result without finished word");

  // each scanline alternates first-byte and next-byte writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_FIRST) |=> (state_q == ST_WR_NEXT))
    else $error("draw sequence broken");

endmodule

// ===== verif/testbench.sv =====
// self-checking bench for glyph_cell_blitter_9x14_core: glyph loads, cell draws and
// frame reads streamed in bursts, read_data checked against a cycle-free image of the buffer
// depends on gcb_pkg and the core rtl
`timescale 1ns / 1ps

module testbench
  import gcb_pkg::*;
;

  localparam int TEXT_LINES     = 25;
  localparam int TEXT_COLS      = 80;
  localparam int ROW_BYTES      = 128;
  localparam int SCANS_PER_CELL = 14;
  localparam int GLYPH_TOP      = 3;
  localparam int FRAME_BYTES    = TEXT_LINES * SCANS_PER_CELL * ROW_BYTES;

  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int RANDOM_WORDS     = 1975;
  localparam int DRAIN_EVERY      = 450;
  localparam int LONG_HOLD_AT     = 700;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 40;
  // the limit also covers the quiet buffer clear after reset
  localparam int STALL_LIMIT      = 200000;
  localparam int REPORT_MAX       = 10;

  // old frame bits that survive a draw, by bit offset of the cell
  localparam logic [7:0][7:0] HOLD_LEFT  = {8'hFF, 8'hFE, 8'hFC, 8'hF8,
                                            8'hF0, 8'hE0, 8'hC0, 8'h00};
  localparam logic [7:0][7:0] HOLD_RIGHT = {8'h00, 8'h00, 8'h01, 8'h03,
                                            8'h07, 8'h0F, 8'h1F, 8'h3F};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] text_line;
    logic [6:0] text_col;
    logic [2:0] glyph_row;
    logic [7:0] glyph_bits;
    logic [8:0] scan_row;
    logic [6:0] row_byte;
    bit         drain_first;
  } blit_word_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  glyph_cell_blitter_9x14_core #(
    .TEXT_LINES(TEXT_LINES),
    .TEXT_COLS (TEXT_COLS),
    .ROW_BYTES (ROW_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predicted state of the block
  logic [7:0] frame_img [FRAME_BYTES];
  logic [7:0] glyph_img [2048];

  // stimulus bookkeeping
  blit_word_t pending_q [$];
  logic [7:0] read_data_q [$];
  bit         row_loaded [2048];
  bit         char_ready [256];
  logic [7:0] ready_chars [$];
  int         recent_cells [$];
  bit         drain_next;

  int fed_cnt      = 0;
  int got_cnt      = 0;
  int mismatch_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] blit_predict(blit_word_t w);
    int         first_b;
    int         base;
    logic [2:0] offs;
    logic [7:0] g;
    logic [7:0] left_bits;
    logic [7:0] right_bits;
    logic [7:0] data;
    data = 8'h00;
    case (w.kind)
      KIND_DRAW: begin
        if (w.text_line < TEXT_LINES && w.text_col < TEXT_COLS) begin
          first_b = int'(w.text_col) * 9 / 8;
          offs    = w.text_col[2:0];
          for (int scan = 0; scan < SCANS_PER_CELL; scan++) begin
            g = 8'h00;
            if (scan >= GLYPH_TOP && scan < GLYPH_TOP + 8)
              g = glyph_img[{w.char_code, 3'(scan - GLYPH_TOP)}];
            base       = (int'(w.text_line) * SCANS_PER_CELL + scan) * ROW_BYTES;
            left_bits  = g >> (int'(offs) + 1);
            right_bits = g << (7 - int'(offs));
            if (first_b < ROW_BYTES)
              frame_img[base + first_b] =
                (frame_img[base + first_b] & HOLD_LEFT[offs]) | left_bits;
            if (first_b + 1 < ROW_BYTES)
              frame_img[base + first_b + 1] =
                (frame_img[base + first_b + 1] & HOLD_RIGHT[offs]) | right_bits;
          end
        end
      end
      KIND_LOAD: glyph_img[{w.char_code, w.glyph_row}] = w.glyph_bits;
      KIND_READ: begin
        if (w.scan_row < TEXT_LINES * SCANS_PER_CELL && w.row_byte < ROW_BYTES)
          data = frame_img[int'(w.scan_row) * ROW_BYTES + int'(w.row_byte)];
      end
      default: ;
    endcase
    return data;
  endfunction

  // every field but the kind and the drain mark starts as noise so unused bits toggle too
  function automatic blit_word_t rand_word();
    blit_word_t w;
    w.kind        = KIND_NONE;
    w.char_code   = 8'($urandom);
    w.text_line   = 5'($urandom);
    w.text_col    = 7'($urandom);
    w.glyph_row   = 3'($urandom);
    w.glyph_bits  = 8'($urandom);
    w.scan_row    = 9'($urandom);
    w.row_byte    = 7'($urandom);
    w.drain_first = 1'b0;
    return w;
  endfunction

  task automatic push_word(blit_word_t w);
    w.drain_first = drain_next;
    drain_next    = 1'b0;
    pending_q.push_back(w);
  endtask

  task automatic queue_load(logic [7:0] code, logic [2:0] row, logic [7:0] bits);
    blit_word_t w;
    bit         all_rows;
    w            = rand_word();
    w.kind       = KIND_LOAD;
    w.char_code  = code;
    w.glyph_row  = row;
    w.glyph_bits = bits;
    push_word(w);
    row_loaded[{code, row}] = 1'b1;
    all_rows = 1'b1;
    for (int r = 0; r < 8; r++) all_rows &= row_loaded[{code, 3'(r)}];
    if (all_rows && !char_ready[code]) begin
      char_ready[code] = 1'b1;
      ready_chars.push_back(code);
    end
  endtask

  task automatic queue_draw(logic [7:0] code, int line, int col);
    blit_word_t w;
    w           = rand_word();
    w.kind      = KIND_DRAW;
    w.char_code = code;
    w.text_line = 5'(line);
    w.text_col  = 7'(col);
    push_word(w);
    if (line < TEXT_LINES && col < TEXT_COLS) begin
      recent_cells.push_back(line * ROW_BYTES + col);
      if (recent_cells.size() > 12) void'(recent_cells.pop_front());
    end
  endtask

  task automatic queue_read(int srow, int rbyte);
    blit_word_t w;
    w          = rand_word();
    w.kind     = KIND_READ;
    w.scan_row = 9'(srow);
    w.row_byte = 7'(rbyte);
    push_word(w);
  endtask

  // sender: bursts of words with random gaps, one word per handshake
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    blit_word_t w;
    bit         took;
    bit         offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        w = pending_q.pop_front();
        read_data_q.push_back(blit_predict(w));
        fed_cnt <= fed_cnt + 1;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      if (!s_axis_tvalid || took) begin
        offer = 1'b0;
        if (gap_left > 0)
          gap_left = gap_left - 1;
        else if (pending_q.size() != 0)
          // a marked word waits until every result is back
          offer = !pending_q[0].drain_first || (!took && fed_cnt == got_cnt);
        if (offer) begin
          w = pending_q[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= w.kind;
          s_axis_tdata  <= {1'b0, w.row_byte, w.scan_row, w.glyph_bits, w.glyph_row,
                            w.text_col, w.text_line, w.char_code};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern of its own plus one long hold-off
  rx_mode_e rx_mode;
  int       mode_left;
  int       hold_left;
  bit       hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && fed_cnt >= LONG_HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left = mode_left - 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom);
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= !m_axis_tready;
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      got_cnt <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got_cnt <= got_cnt + 1;
      if (read_data_q.size() == 0) begin
        if (mismatch_cnt < REPORT_MAX)
          $display("unexpected word %0d: read_data %02h", got_cnt, m_axis_tdata);
        mismatch_cnt = mismatch_cnt + 1;
      end else begin
        want = read_data_q.pop_front();
        if (m_axis_tdata !== want) begin
          if (mismatch_cnt < REPORT_MAX)
            $display("word %0d read_data: expected %02h, got %02h",
                     got_cnt, want, m_axis_tdata);
          mismatch_cnt = mismatch_cnt + 1;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet = quiet + 1;
    end
    $display("glyph_cell_blitter_9x14_core verification failed");
    $finish;
  end

  initial begin : stimulus
    localparam logic [63:0] DIRECTED_ROWS = 64'hC3FF_55AA_0001_80FF;
    blit_word_t w;
    int         total_words;
    int         next_drain;
    int         pick;
    int         cell_key;
    int         line;
    int         col;
    logic [7:0] code;

    foreach (frame_img[i]) frame_img[i] = 8'h00;
    drain_next = 1'b0;

    // directed: unused kind, reads at and past the frame edges, one glyph,
    // draws at every bit offset with overlapping neighbors, the last cell,
    // draws off the screen, then reads of drawn bytes
    push_word(rand_word());
    queue_read(TEXT_LINES * SCANS_PER_CELL - 1, ROW_BYTES - 1);
    queue_read(TEXT_LINES * SCANS_PER_CELL, 0);
    queue_read(511, 127);
    for (int r = 0; r < 8; r++) queue_load(8'hA5, 3'(r), DIRECTED_ROWS[r * 8 +: 8]);
    for (int c = 0; c < 8; c++) queue_draw(8'hA5, 0, c);
    queue_draw(8'hA5, TEXT_LINES - 1, TEXT_COLS - 1);
    queue_draw(8'hA5, TEXT_LINES, 3);
    queue_draw(8'hA5, 4, TEXT_COLS);
    queue_read(GLYPH_TOP, 0);
    queue_read((TEXT_LINES - 1) * SCANS_PER_CELL + 5, (TEXT_COLS - 1) * 9 / 8 + 1);

    total_words = pending_q.size() + RANDOM_WORDS;
    next_drain  = DRAIN_EVERY;
    while (pending_q.size() < total_words) begin
      if (pending_q.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain = next_drain + DRAIN_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        code = 8'($urandom);
        for (int r = 0; r < 8; r++) queue_load(code, 3'(r), 8'($urandom));
      end else if (pick < 14) begin
        queue_load(8'($urandom), 3'($urandom), 8'($urandom));
      end else if (pick < 48) begin
        queue_draw(ready_chars[$urandom_range(0, ready_chars.size() - 1)],
                   $urandom_range(0, TEXT_LINES - 1), $urandom_range(0, TEXT_COLS - 1));
      end else if (pick < 52) begin
        code = ready_chars[$urandom_range(0, ready_chars.size() - 1)];
        if ($urandom_range(0, 1) == 0)
          queue_draw(code, $urandom_range(TEXT_LINES, 31), $urandom_range(0, 127));
        else
          queue_draw(code, $urandom_range(0, 31), $urandom_range(TEXT_COLS, 127));
      end else if (pick < 86 && recent_cells.size() != 0) begin
        // read back a byte of a recently drawn cell
        cell_key = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
        line     = cell_key / ROW_BYTES;
        col      = cell_key % ROW_BYTES;
        queue_read(line * SCANS_PER_CELL + $urandom_range(0, SCANS_PER_CELL - 1),
                   col * 9 / 8 + $urandom_range(0, 1));
      end else if (pick < 95) begin
        queue_read($urandom_range(0, 511), $urandom_range(0, 127));
      end else begin
        push_word(rand_word());
      end
    end
    total_words = pending_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (fed_cnt == total_words && got_cnt == total_words);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && read_data_q.size() == 0)
      $display("glyph_cell_blitter_9x14_core verification clean");
    else
      $display("glyph_cell_blitter_9x14_core verification failed");
    $finish;
  end

endmodule
